[hdl/gped_pkg.sv]
// ----------------------------------------------------------------------------
// gped_pkg
// Shared types and constants for the gamepad edge and dead zone block.
// ----------------------------------------------------------------------------
package gped_pkg;

    // fixed device geometry
    localparam int NUM_BUTTONS_C = 16;
    localparam int NUM_AXES_C    = 4;
    localparam int AXIS_BITS_C   = 16;

    localparam int BTN_IDX_W  = 4;
    localparam int BTN_CNT_W  = 5;
    localparam int AXIS_CNT_W = 3;
    localparam int AX_IDX_W   = 2;

    // dead zone register, unsigned q0.15
    localparam int DZ_BITS = 15;
    localparam logic [DZ_BITS-1:0] DZ_RESET = 15'd16384;
    localparam logic [DZ_BITS:0]   DZ_ONE   = 16'h8000;

    // saturated counts
    localparam logic [BTN_CNT_W-1:0]  BTN_CNT_MAX  = 5'd16;
    localparam logic [AXIS_CNT_W-1:0] AXIS_CNT_MAX = 3'd4;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AXES,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic advance;
    } scan_ctrl_t;

    typedef struct packed {
        logic                 busy;
        logic                 event_hit;
        logic                 press;
        logic [BTN_IDX_W-1:0] index;
    } scan_stat_t;

endpackage

[hdl/gped_divider.sv]
// ----------------------------------------------------------------------------
// gped_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gped_divider
    import gped_pkg::*;
#(
    parameter int QBITS = AXIS_BITS_C
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DZ_BITS-1:0] rem_init,
    input  logic [QBITS-1:0]   numer_lo,
    input  logic [DZ_BITS:0]   divisor,
    output logic               done,
    output logic [QBITS-1:0]   quotient
);

    localparam int CNT_W = $clog2(QBITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DZ_BITS-1:0] rem_reg;
    logic [QBITS-1:0]   acc_reg;
    logic [DZ_BITS:0]   dvs_reg;

    logic [DZ_BITS:0]   trial;
    logic [DZ_BITS:0]   diff;
    logic               fits;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        trial = {rem_reg, acc_reg[QBITS-1]};
        fits  = (trial >= dvs_reg);
        diff  = trial - dvs_reg;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            acc_reg <= numer_lo;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DZ_BITS-1:0] : trial[DZ_BITS-1:0];
            acc_reg <= {acc_reg[QBITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

[hdl/gped_dead_zone.sv]
// ----------------------------------------------------------------------------
// gped_dead_zone
// Walks the axes one at a time through the shared divider and returns the
// scaled, saturated and signed result for each.
// ----------------------------------------------------------------------------
module gped_dead_zone
    import gped_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_C
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [AXIS_BITS-1:0] axis_in [NUM_AXES_C],
    input  logic [AXIS_CNT_W-1:0]       axis_count,
    input  logic [DZ_BITS-1:0]          dead_zone,
    output logic                        busy,
    output logic                        wr_en,
    output logic [AX_IDX_W-1:0]         wr_idx,
    output logic signed [AXIS_BITS-1:0] wr_data
);

    localparam int NUM_W = AXIS_BITS + DZ_BITS + 1;
    localparam logic [AX_IDX_W-1:0]  IDX_LAST = AX_IDX_W'(NUM_AXES_C - 1);
    localparam logic [AXIS_BITS-1:0] SAT_MAX  = {1'b0, {(AXIS_BITS-1){1'b1}}};

    logic                  busy_reg;
    logic                  kick_reg;
    logic [AX_IDX_W-1:0]   idx_reg;
    logic [AXIS_BITS-1:0]  mag_sr [NUM_AXES_C];
    logic [NUM_AXES_C-1:0] sign_sr;
    logic                  neg_reg;
    logic [AXIS_CNT_W-1:0] count_reg;
    logic [DZ_BITS-1:0]    dz_reg;

    logic [NUM_W-1:0]      m_ext;
    logic [NUM_W-1:0]      d_ext;
    logic [NUM_W-1:0]      diff;
    logic [NUM_W-2:0]      numer;
    logic [DZ_BITS:0]      divisor;
    logic                  div_done;
    logic [AXIS_BITS-1:0]  quot;
    logic [AXIS_BITS-1:0]  sat;

    // numerator |x|*2^15 - d*2^(bits-1), clamped at zero
    always_comb
    begin
        m_ext   = {1'b0, mag_sr[0], {DZ_BITS{1'b0}}};
        d_ext   = {2'b00, dz_reg, {(AXIS_BITS-1){1'b0}}};
        diff    = m_ext - d_ext;
        numer   = (!diff[NUM_W-1] && (diff != '0)) ? diff[NUM_W-2:0] : '0;
        divisor = DZ_ONE - {1'b0, dz_reg};
    end

    gped_divider #(
        .QBITS    (AXIS_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kick_reg),
        .rem_init (numer[NUM_W-2:AXIS_BITS]),
        .numer_lo (numer[AXIS_BITS-1:0]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quot)
    );

    // the quotient never exceeds full scale, which saturates one below
    always_comb
    begin
        sat     = quot[AXIS_BITS-1] ? SAT_MAX : quot;
        wr_data = neg_reg ? $signed(AXIS_BITS'(-sat)) : $signed(sat);
        wr_en   = div_done && ({1'b0, idx_reg} < count_reg);
        wr_idx  = idx_reg;
    end

    // sequencing over the axes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            kick_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            kick_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                kick_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (div_done)
            begin
                if (idx_reg == IDX_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg  <= idx_reg + 1'b1;
                    kick_reg <= 1'b1;
                end
            end
        end
    end

    // axis magnitude shift line
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < NUM_AXES_C; i++)
            begin
                mag_sr[i]  <= axis_in[i][AXIS_BITS-1] ? AXIS_BITS'(-axis_in[i])
                                                      : axis_in[i];
                sign_sr[i] <= axis_in[i][AXIS_BITS-1];
            end
            count_reg <= axis_count;
            dz_reg    <= dead_zone;
        end
        else if (div_done)
        begin
            for (int i = 0; i < NUM_AXES_C - 1; i++)
            begin
                mag_sr[i] <= mag_sr[i+1];
            end
            sign_sr <= sign_sr >> 1;
        end
        if (kick_reg)
        begin
            neg_reg <= sign_sr[0];
        end
    end

    assign busy = busy_reg;

endmodule

[hdl/gped_button_scan.sv]
// ----------------------------------------------------------------------------
// gped_button_scan
// Serial button scan: shifts the new bitmap against the stored one, one
// button per step, and flags every change.
// ----------------------------------------------------------------------------
module gped_button_scan
    import gped_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  scan_ctrl_t               ctrl,
    input  logic [NUM_BUTTONS_C-1:0] bits,
    input  logic [BTN_CNT_W-1:0]     count,
    output scan_stat_t               stat
);

    localparam logic [BTN_IDX_W-1:0] IDX_LAST = BTN_IDX_W'(NUM_BUTTONS_C - 1);

    logic                     busy_reg;
    logic [BTN_IDX_W-1:0]     idx_reg;
    logic [NUM_BUTTONS_C-1:0] new_sr;
    logic [NUM_BUTTONS_C-1:0] old_reg;
    logic [BTN_CNT_W-1:0]     count_reg;

    logic now_bit;
    logic was_bit;

    // bits at or above the count never read as pressed
    always_comb
    begin
        now_bit        = new_sr[0] && ({1'b0, idx_reg} < count_reg);
        was_bit        = old_reg[0];
        stat.busy      = busy_reg;
        stat.event_hit = busy_reg && (now_bit != was_bit);
        stat.press     = now_bit;
        stat.index     = idx_reg;
    end

    // scan control and stored button states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            old_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            if (ctrl.clear)
            begin
                old_reg <= '0;
            end
        end
        else if (ctrl.advance && busy_reg)
        begin
            old_reg <= {now_bit, old_reg[NUM_BUTTONS_C-1:1]};
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg == IDX_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // new bitmap shift register
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            new_sr    <= bits;
            count_reg <= count;
        end
        else if (ctrl.advance && busy_reg)
        begin
            new_sr <= new_sr >> 1;
        end
    end

endmodule

[hdl/gamepad_edge_and_dead_zone.sv]
// ----------------------------------------------------------------------------
// gamepad_edge_and_dead_zone
// Gamepad poll processor: button press/release events and scaled dead zone.
// ----------------------------------------------------------------------------
// One poll word enters on the in channel (in_valid/in_ready). For a connected
// pad it produces a press or release word for each changed button, lowest
// index first, then one summary word with the dead-zoned axes; a poll of a
// detached pad gives only the summary. last_of_run marks the summary word.
// The dead_zone register is written on the cfg channel (cfg_valid/cfg_ready),
// always ready; the user must write it only while the block is idle, as the
// block itself does not enforce this. Button words come out during the serial
// button scan; the summary follows once each axis in turn has passed through
// the bit-serial divider. A detached poll skips the scan and the divider and
// gives only its summary. The block takes no new poll until the summary word
// of the current one is loaded, as in_ready is high only while the sequencer
// idles.
// Reset leaves the pad disconnected, buttons released, axes zero and the
// dead zone at one half. A stalled receiver holds the output word; the button
// scan pauses on a change until the word slot frees up.
// ----------------------------------------------------------------------------
module gamepad_edge_and_dead_zone
    import gped_pkg::*;
#(
    parameter int AXIS_BITS = AXIS_BITS_C
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // poll input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        present,
    input  logic [BTN_CNT_W-1:0]        button_count,
    input  logic [NUM_BUTTONS_C-1:0]    button_bits,
    input  logic [AXIS_CNT_W-1:0]       axis_count,
    input  logic signed [AXIS_BITS-1:0] axis_in_0,
    input  logic signed [AXIS_BITS-1:0] axis_in_1,
    input  logic signed [AXIS_BITS-1:0] axis_in_2,
    input  logic signed [AXIS_BITS-1:0] axis_in_3,
    // result output
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [BTN_IDX_W-1:0]        button_index,
    output logic                        is_connected,
    output logic signed [AXIS_BITS-1:0] axis_out_0,
    output logic signed [AXIS_BITS-1:0] axis_out_1,
    output logic signed [AXIS_BITS-1:0] axis_out_2,
    output logic signed [AXIS_BITS-1:0] axis_out_3,
    output logic                        last_of_run,
    // configuration
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [DZ_BITS-1:0]          dead_zone
);

    state_t                state_reg;
    state_t                state_next;

    logic [DZ_BITS-1:0]    dead_zone_reg;
    logic                  connected_reg;
    logic [BTN_CNT_W-1:0]  known_bc_reg;
    logic [AXIS_CNT_W-1:0] known_ac_reg;
    logic signed [AXIS_BITS-1:0] axis_reg [NUM_AXES_C];

    logic                  out_valid_reg;
    kind_t                 kind_reg;
    logic [BTN_IDX_W-1:0]  index_reg;
    logic                  conn_out_reg;
    logic                  last_reg;
    logic signed [AXIS_BITS-1:0] out_axis_reg [NUM_AXES_C];

    logic                  in_accept;
    logic                  slot_free;
    logic                  ev_load;
    logic                  sum_load;
    logic                  poll_start;
    logic [BTN_CNT_W-1:0]  bc_sat;
    logic [AXIS_CNT_W-1:0] ac_sat;

    logic signed [AXIS_BITS-1:0] axis_in_arr [NUM_AXES_C];
    scan_ctrl_t            scan_ctrl;
    scan_stat_t            scan_st;
    logic                  dz_busy;
    logic                  dz_wr_en;
    logic [AX_IDX_W-1:0]   dz_wr_idx;
    logic signed [AXIS_BITS-1:0] dz_wr_data;

    // input decode
    always_comb
    begin
        in_accept      = in_valid && in_ready;
        poll_start     = in_accept && present;
        slot_free      = !out_valid_reg || out_ready;
        bc_sat         = (button_count > BTN_CNT_MAX) ? BTN_CNT_MAX : button_count;
        ac_sat         = (axis_count > AXIS_CNT_MAX) ? AXIS_CNT_MAX : axis_count;
        axis_in_arr[0] = axis_in_0;
        axis_in_arr[1] = axis_in_1;
        axis_in_arr[2] = axis_in_2;
        axis_in_arr[3] = axis_in_3;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = present ? ST_SCAN : ST_SUMMARY;
                end
            end
            ST_SCAN:
            begin
                if (!scan_st.busy)
                begin
                    state_next = ST_AXES;
                end
            end
            ST_AXES:
            begin
                if (!dz_busy)
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready          = (state_reg == ST_IDLE);
        ev_load           = (state_reg == ST_SCAN) && scan_st.event_hit && slot_free;
        sum_load          = (state_reg == ST_SUMMARY) && slot_free;
        scan_ctrl.start   = poll_start;
        scan_ctrl.clear   = (bc_sat != known_bc_reg);
        scan_ctrl.advance = (state_reg == ST_SCAN) && scan_st.busy
                            && (!scan_st.event_hit || slot_free);
    end

    gped_button_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .bits  (button_bits),
        .count (bc_sat),
        .stat  (scan_st)
    );

    gped_dead_zone #(
        .AXIS_BITS  (AXIS_BITS)
    ) u_dz (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (poll_start),
        .axis_in    (axis_in_arr),
        .axis_count (ac_sat),
        .dead_zone  (dead_zone_reg),
        .busy       (dz_busy),
        .wr_en      (dz_wr_en),
        .wr_idx     (dz_wr_idx),
        .wr_data    (dz_wr_data)
    );

    // sequencer state and poll state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dead_zone_reg <= DZ_RESET;
            connected_reg <= 1'b0;
            known_bc_reg  <= '0;
            known_ac_reg  <= AXIS_CNT_MAX;
            for (int i = 0; i < NUM_AXES_C; i++)
            begin
                axis_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                dead_zone_reg <= dead_zone;
            end
            if (in_accept)
            begin
                connected_reg <= present;
            end
            if (poll_start)
            begin
                known_bc_reg <= bc_sat;
                if (ac_sat != known_ac_reg)
                begin
                    known_ac_reg <= ac_sat;
                    for (int i = 0; i < NUM_AXES_C; i++)
                    begin
                        axis_reg[i] <= '0;
                    end
                end
            end
            else if (dz_wr_en)
            begin
                axis_reg[dz_wr_idx] <= dz_wr_data;
            end
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ev_load || sum_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (ev_load)
        begin
            kind_reg     <= scan_st.press ? KIND_PRESS : KIND_RELEASE;
            index_reg    <= scan_st.index;
            conn_out_reg <= connected_reg;
            last_reg     <= 1'b0;
            for (int i = 0; i < NUM_AXES_C; i++)
            begin
                out_axis_reg[i] <= '0;
            end
        end
        else if (sum_load)
        begin
            kind_reg     <= KIND_SUMMARY;
            index_reg    <= '0;
            conn_out_reg <= connected_reg;
            last_reg     <= 1'b1;
            for (int i = 0; i < NUM_AXES_C; i++)
            begin
                out_axis_reg[i] <= (AXIS_CNT_W'(i) < known_ac_reg) ? axis_reg[i] : '0;
            end
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign button_index = index_reg;
    assign is_connected = conn_out_reg;
    assign last_of_run  = last_reg;
    assign axis_out_0   = out_axis_reg[0];
    assign axis_out_1   = out_axis_reg[1];
    assign axis_out_2   = out_axis_reg[2];
    assign axis_out_3   = out_axis_reg[3];

`ifndef SYNTHESIS
    // a new poll is taken only when both serial units are quiet
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!scan_st.busy && !dz_busy))
        else $error("poll accepted while a serial unit is busy");

    // the summary word is always the last of its run
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        sum_load |=> (out_valid && last_of_run && (kind == KIND_SUMMARY)))
        else $error("summary word not marked last");

    // button words only come from a connected pad
    a_event_conn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> is_connected)
        else $error("button word while disconnected");
`endif

endmodule
